@@ src/tmrg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrg_pkg: shared types and constants of the tube mesh ring generator
// Coordinate formats, internal arithmetic widths and the job record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tmrg_pkg;

	// coordinate format: signed, FRAC_BITS fraction bits
	localparam int CW        = 24;
	localparam int FRAC_BITS = 12;
	localparam int DW        = CW + 1;          // tangent component width

	// radius register
	localparam int RADIUS_W     = 16;
	localparam int RADIUS_FRAC  = 12;
	localparam int RADIUS_RESET = 410;

	// normalized magnitudes stay below 2^NM_W
	localparam int NM_W   = 30;
	localparam int SQ_W   = 2 * NM_W + 2;       // sum of three squares
	localparam int RAD_W  = 64;                 // square root radicand
	localparam int RT_W   = 31;                 // square root result
	localparam int A_W    = RT_W;               // ratio numerator
	localparam int NUM_W  = A_W + 17;           // (a << 16) + r/2
	localparam int QUO_W  = 17;                 // ratio quotient bits

	// cosines and sines: 16 fraction bits, one = 65536
	localparam int TRIG_W   = 18;
	localparam int TRIG_ONE = 65536;

	// offsets
	localparam int PROD_W = 2 * TRIG_W;
	localparam int PM_W   = 33;                 // |product| <= 2^32
	localparam int MR_W   = PM_W + RADIUS_W;
	localparam int SCALE_SH = 32 + RADIUS_FRAC - FRAC_BITS;
	localparam int OFF_W  = 18;
	localparam int SUM_W  = ((CW > OFF_W) ? CW : OFF_W) + 1;

	// stream payload
	localparam int TDATA_W = ((3 * CW + 7) / 8) * 8;
	localparam int TUSER_W = 4;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;

	// one closed window: ring centres and tangents
	typedef struct packed {
		coord_t [2:0] p1;
		coord_t [2:0] p2;
		diff_t  [2:0] d1;
		diff_t  [2:0] d2;
	} job_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ src/tmrg_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrg_fifo: two-entry job queue
// Decouples the point front end from the ring back end.
// ----------------------------------------------------------------------------
module tmrg_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tmrg_pkg::job_t    wdata,
	input  logic              pop,
	output tmrg_pkg::job_t    rdata,
	output tmrg_pkg::q_stat_t stat
);

	tmrg_pkg::job_t mem_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign rdata      = mem_q[rp_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

endmodule

@@ src/tmrg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrg_front: point window and job builder
// Holds the last three samples; a sample that closes a window becomes a job
// with both ring centres and both tangents.
// ----------------------------------------------------------------------------
module tmrg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tmrg_pkg::TDATA_W-1:0]  s_tdata,
	input  logic                          s_tuser,
	input  tmrg_pkg::q_stat_t             qstat,
	output logic                          push,
	output tmrg_pkg::job_t                job
);

	tmrg_pkg::coord_t [2:0] win_q [3];
	logic [1:0]             seen_q;
	logic [1:0]             eff_seen;
	logic                   accept;
	logic                   closes;
	tmrg_pkg::coord_t [2:0] p3;

	assign p3[0] = s_tdata[tmrg_pkg::CW-1:0];
	assign p3[1] = s_tdata[2*tmrg_pkg::CW-1:tmrg_pkg::CW];
	assign p3[2] = s_tdata[3*tmrg_pkg::CW-1:2*tmrg_pkg::CW];

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;
	assign eff_seen = s_tuser ? 2'd0 : seen_q;
	assign closes   = (eff_seen == 2'd3);
	assign push     = accept && closes;

	// job: centres p1, p2; tangents p2 - p0 and p3 - p1
	always_comb begin
		job.p1 = win_q[1];
		job.p2 = win_q[2];
		for (int i = 0; i < 3; i++) begin
			job.d1[i] = tmrg_pkg::DW'($signed(win_q[2][i])) -
				tmrg_pkg::DW'($signed(win_q[0][i]));
			job.d2[i] = tmrg_pkg::DW'($signed(p3[i])) -
				tmrg_pkg::DW'($signed(win_q[1][i]));
		end
	end

	// window fill and slide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
			for (int j = 0; j < 3; j++) begin
				win_q[j] <= '0;
			end
		end else if (accept) begin
			if (closes) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= p3;
			end else begin
				case (eff_seen)
					2'd0: win_q[0] <= p3;
					2'd1: win_q[1] <= p3;
					default: win_q[2] <= p3;
				endcase
				seen_q <= eff_seen + 2'd1;
			end
		end
	end

endmodule

@@ src/tmrg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrg_back: ring orientation, offsets and vertex output
// Per tangent: magnitudes, normalization, squares, two bit-serial square
// roots, four bit-serial ratios and five scaled offsets; then 16 vertices.
// ----------------------------------------------------------------------------
module tmrg_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tmrg_pkg::job_t                job,
	input  tmrg_pkg::q_stat_t             qstat,
	output logic                          pop,
	input  logic [tmrg_pkg::RADIUS_W-1:0] radius,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tmrg_pkg::TDATA_W-1:0]  m_tdata,
	output logic [tmrg_pkg::TUSER_W-1:0]  m_tuser,
	output logic                          m_tlast
);

	typedef enum logic [3:0] {
		S_IDLE, S_ABS, S_NORM, S_SQ, S_RINIT, S_ROOT, S_DINIT, S_DIV, S_OFF, S_EMIT
	} state_t;

	// ring offsets: o0 = (x0, y0, 0), o1 = (x1, y1, z1)
	typedef struct packed {
		logic signed [tmrg_pkg::OFF_W-1:0] x0;
		logic signed [tmrg_pkg::OFF_W-1:0] y0;
		logic signed [tmrg_pkg::OFF_W-1:0] x1;
		logic signed [tmrg_pkg::OFF_W-1:0] y1;
		logic signed [tmrg_pkg::OFF_W-1:0] z1;
	} ring_t;

	localparam logic signed [tmrg_pkg::TRIG_W-1:0] ONE = tmrg_pkg::TRIG_W'(tmrg_pkg::TRIG_ONE);
	localparam logic [tmrg_pkg::QUO_W-1:0] QONE = tmrg_pkg::QUO_W'(tmrg_pkg::TRIG_ONE);
	localparam logic signed [tmrg_pkg::SUM_W-1:0] V_HI =
		{{(tmrg_pkg::SUM_W-tmrg_pkg::CW+1){1'b0}}, {(tmrg_pkg::CW-1){1'b1}}};
	localparam logic signed [tmrg_pkg::SUM_W-1:0] V_LO = ~V_HI;
	localparam logic [tmrg_pkg::MR_W:0] RND = (tmrg_pkg::MR_W+1)'(1) << (tmrg_pkg::SCALE_SH-1);

	state_t                              state_q;
	tmrg_pkg::job_t                      job_q;
	logic                                tsel_q;
	logic [tmrg_pkg::DW-1:0]             m_q [3];
	logic [2:0]                          neg_q;
	logic [4:0]                          cnt_q;
	logic [tmrg_pkg::SQ_W-1:0]           acc_q;
	logic [tmrg_pkg::SQ_W-1:0]           sxy_q;
	logic [tmrg_pkg::SQ_W-1:0]           sd_q;
	logic                                rsel_q;
	logic [tmrg_pkg::RAD_W-1:0]          rad_q;
	logic [tmrg_pkg::RT_W+3:0]           rem_q;
	logic [tmrg_pkg::RT_W:0]             root_q;
	logic [tmrg_pkg::RT_W-1:0]           rxy_q;
	logic [tmrg_pkg::RT_W-1:0]           rd_q;
	logic [1:0]                          dsel_q;
	logic [tmrg_pkg::QUO_W-1:0]          nlow_q;
	logic [tmrg_pkg::RT_W:0]             drem_q;
	logic [tmrg_pkg::QUO_W-1:0]          quo_q;
	logic signed [tmrg_pkg::TRIG_W-1:0]  t_q [4];
	logic [2:0]                          item_q;
	logic [1:0]                          ph_q;
	logic signed [tmrg_pkg::PROD_W-1:0]  prod_s1;
	logic                                pneg_q;
	logic [tmrg_pkg::MR_W-1:0]           mr_q;
	ring_t                               ring1_q;
	ring_t                               ring2_q;
	logic                                mv_q;
	logic [tmrg_pkg::TDATA_W-1:0]        md_q;
	logic [tmrg_pkg::TUSER_W-1:0]        mu_q;
	logic                                ml_q;

	// combinational helpers
	logic [tmrg_pkg::NM_W-1:0]           mn [3];
	logic                                ovf;
	logic                                xy_zero;
	logic                                all_zero;
	logic [tmrg_pkg::NM_W-1:0]           sqm;
	logic [2*tmrg_pkg::NM_W-1:0]         sqp;
	logic [tmrg_pkg::SQ_W-1:0]           acc_n;
	logic [tmrg_pkg::RT_W+3:0]           remn;
	logic [tmrg_pkg::RT_W+3:0]           trial;
	logic                                rge;
	logic [tmrg_pkg::RT_W:0]             root_n;
	logic [tmrg_pkg::A_W-1:0]            div_a;
	logic [tmrg_pkg::RT_W-1:0]           div_r;
	logic [tmrg_pkg::NUM_W-1:0]          num;
	logic [tmrg_pkg::RT_W:0]             dr;
	logic                                dge;
	logic [tmrg_pkg::QUO_W-1:0]          quo_n;
	logic [tmrg_pkg::QUO_W-1:0]          qc;
	logic signed [tmrg_pkg::TRIG_W-1:0]  tv;
	logic signed [tmrg_pkg::TRIG_W-1:0]  tnew;
	logic signed [tmrg_pkg::TRIG_W-1:0]  opa;
	logic signed [tmrg_pkg::TRIG_W-1:0]  opb;
	logic [tmrg_pkg::PROD_W-1:0]         pabs;
	logic [tmrg_pkg::MR_W:0]             mrr;
	logic [tmrg_pkg::OFF_W-2:0]          ofs_mag;
	logic signed [tmrg_pkg::OFF_W-1:0]   ofs;
	logic                                out_free;
	logic                                emit_go;
	logic [1:0]                          eq;
	logic [1:0]                          ec;
	logic                                use_r2;
	logic [1:0]                          ek;
	ring_t                               er;
	tmrg_pkg::coord_t [2:0]              ecen;
	logic signed [tmrg_pkg::OFF_W-1:0]   eo [3];
	tmrg_pkg::coord_t                    ev [3];

	function automatic tmrg_pkg::coord_t sat(input logic signed [tmrg_pkg::SUM_W-1:0] v);
		tmrg_pkg::coord_t r;
		if (v > V_HI) begin
			r = tmrg_pkg::CW'(V_HI);
		end else if (v < V_LO) begin
			r = tmrg_pkg::CW'(V_LO);
		end else begin
			r = tmrg_pkg::CW'(v);
		end
		return r;
	endfunction

	assign pop = (state_q == S_IDLE) && !qstat.empty;

	// normalized magnitudes and special-case flags
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mn[i] = tmrg_pkg::NM_W'(m_q[i]);
		end
		ovf = ((m_q[0] >> tmrg_pkg::NM_W) != '0) || ((m_q[1] >> tmrg_pkg::NM_W) != '0) ||
			((m_q[2] >> tmrg_pkg::NM_W) != '0);
		xy_zero  = (mn[0] == '0) && (mn[1] == '0);
		all_zero = xy_zero && (mn[2] == '0);
	end

	// squaring step
	always_comb begin
		case (cnt_q[1:0])
			2'd0: sqm = mn[0];
			2'd1: sqm = mn[1];
			default: sqm = mn[2];
		endcase
		sqp   = sqm * sqm;
		acc_n = acc_q + tmrg_pkg::SQ_W'(sqp);
	end

	// square root step, two radicand bits per cycle
	always_comb begin
		remn   = {rem_q[tmrg_pkg::RT_W+1:0], rad_q[tmrg_pkg::RAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		rge    = (remn >= trial);
		root_n = {root_q[tmrg_pkg::RT_W-1:0], rge};
	end

	// ratio operands and long division step
	always_comb begin
		case (dsel_q)
			2'd0: begin
				div_a = tmrg_pkg::A_W'(mn[0]);
				div_r = rxy_q;
			end
			2'd1: begin
				div_a = tmrg_pkg::A_W'(mn[1]);
				div_r = rxy_q;
			end
			2'd2: begin
				div_a = tmrg_pkg::A_W'(mn[2]);
				div_r = rd_q;
			end
			default: begin
				div_a = rxy_q;
				div_r = rd_q;
			end
		endcase
		num   = {1'b0, div_a, 16'd0} + tmrg_pkg::NUM_W'(div_r >> 1);
		dr    = {drem_q[tmrg_pkg::RT_W-1:0], nlow_q[tmrg_pkg::QUO_W-1]};
		dge   = (dr >= {1'b0, div_r});
		quo_n = {quo_q[tmrg_pkg::QUO_W-2:0], dge};
		qc    = (quo_n > QONE) ? QONE : quo_n;
		tv    = tmrg_pkg::TRIG_W'({1'b0, qc});
		case (dsel_q)
			2'd0: tnew = xy_zero ? ONE : tv;
			2'd1: tnew = xy_zero ? '0 : ((neg_q[0] ^ neg_q[1]) ? -tv : tv);
			2'd2: tnew = all_zero ? ONE : (neg_q[2] ? -tv : tv);
			default: tnew = all_zero ? '0 : tv;
		endcase
	end

	// offset operands: item order cp, sp, sp*st, -(cp*st), ct
	always_comb begin
		case (item_q)
			3'd0: begin
				opa = t_q[2];
				opb = ONE;
			end
			3'd1: begin
				opa = t_q[3];
				opb = ONE;
			end
			3'd2: begin
				opa = t_q[3];
				opb = t_q[1];
			end
			3'd3: begin
				opa = t_q[2];
				opb = t_q[1];
			end
			default: begin
				opa = t_q[0];
				opb = ONE;
			end
		endcase
		pabs    = prod_s1[tmrg_pkg::PROD_W-1] ? tmrg_pkg::PROD_W'(-prod_s1) : prod_s1;
		mrr     = {1'b0, mr_q} + RND;
		ofs_mag = mrr[tmrg_pkg::SCALE_SH +: (tmrg_pkg::OFF_W-1)];
		ofs     = pneg_q ? -$signed({1'b0, ofs_mag}) : $signed({1'b0, ofs_mag});
	end

	// vertex selection: corners ring1[q], ring2[q], ring2[q+1], ring1[q+1]
	always_comb begin
		eq     = cnt_q[3:2];
		ec     = cnt_q[1:0];
		use_r2 = (ec == 2'd1) || (ec == 2'd2);
		ek     = use_r2 ? ((ec == 2'd1) ? eq : eq + 2'd1) : ((ec == 2'd0) ? eq : eq + 2'd1);
		er     = use_r2 ? ring2_q : ring1_q;
		ecen   = use_r2 ? job_q.p2 : job_q.p1;
		eo[0]  = ek[0] ? er.x1 : er.x0;
		eo[1]  = ek[0] ? er.y1 : er.y0;
		eo[2]  = ek[0] ? er.z1 : '0;
		for (int i = 0; i < 3; i++) begin
			if (ek[1]) begin
				eo[i] = -eo[i];
			end
			ev[i] = sat(tmrg_pkg::SUM_W'($signed(ecen[i])) + tmrg_pkg::SUM_W'(eo[i]));
		end
	end

	assign out_free = !mv_q || m_tready;
	assign emit_go  = (state_q == S_EMIT) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tsel_q  <= 1'b0;
			cnt_q   <= '0;
			rsel_q  <= 1'b0;
			dsel_q  <= 2'd0;
			item_q  <= 3'd0;
			ph_q    <= 2'd0;
			mv_q    <= 1'b0;
		end else begin
			// output register: load on emit, clear once taken
			if (emit_go) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!qstat.empty) begin
						job_q   <= job;
						tsel_q  <= 1'b0;
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					for (int i = 0; i < 3; i++) begin
						if (tsel_q) begin
							neg_q[i] <= job_q.d2[i][tmrg_pkg::DW-1];
							m_q[i]   <= job_q.d2[i][tmrg_pkg::DW-1] ?
								tmrg_pkg::DW'(-$signed(job_q.d2[i])) : job_q.d2[i];
						end else begin
							neg_q[i] <= job_q.d1[i][tmrg_pkg::DW-1];
							m_q[i]   <= job_q.d1[i][tmrg_pkg::DW-1] ?
								tmrg_pkg::DW'(-$signed(job_q.d1[i])) : job_q.d1[i];
						end
					end
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (ovf) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] >> 1;
						end
					end else begin
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					acc_q <= acc_n;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd1) begin
						sxy_q <= acc_n;
					end
					if (cnt_q == 5'd2) begin
						sd_q    <= acc_n;
						rsel_q  <= 1'b0;
						state_q <= S_RINIT;
					end
				end
				S_RINIT: begin
					rad_q   <= tmrg_pkg::RAD_W'(rsel_q ? sd_q : sxy_q);
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					rem_q  <= rge ? remn - trial : remn;
					root_q <= root_n;
					rad_q  <= rad_q << 2;
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'(tmrg_pkg::RAD_W / 2 - 1)) begin
						if (rsel_q) begin
							rd_q    <= tmrg_pkg::RT_W'(root_n);
							dsel_q  <= 2'd0;
							state_q <= S_DINIT;
						end else begin
							rxy_q   <= tmrg_pkg::RT_W'(root_n);
							rsel_q  <= 1'b1;
							state_q <= S_RINIT;
						end
					end
				end
				S_DINIT: begin
					drem_q  <= (tmrg_pkg::RT_W+1)'(num >> tmrg_pkg::QUO_W);
					nlow_q  <= num[tmrg_pkg::QUO_W-1:0];
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					drem_q <= dge ? dr - {1'b0, div_r} : dr;
					quo_q  <= quo_n;
					nlow_q <= nlow_q << 1;
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'(tmrg_pkg::QUO_W - 1)) begin
						t_q[dsel_q] <= tnew;
						dsel_q      <= dsel_q + 2'd1;
						if (dsel_q == 2'd3) begin
							item_q  <= 3'd0;
							ph_q    <= 2'd0;
							state_q <= S_OFF;
						end else begin
							state_q <= S_DINIT;
						end
					end
				end
				S_OFF: begin
					case (ph_q)
						2'd0: begin
							prod_s1 <= opa * opb;
							pneg_q  <= (item_q == 3'd3);
							ph_q    <= 2'd1;
						end
						2'd1: begin
							mr_q   <= tmrg_pkg::PM_W'(pabs) * radius;
							pneg_q <= pneg_q ^ prod_s1[tmrg_pkg::PROD_W-1];
							ph_q   <= 2'd2;
						end
						default: begin
							ph_q   <= 2'd0;
							item_q <= item_q + 3'd1;
							if (tsel_q) begin
								case (item_q)
									3'd0: ring2_q.x0 <= ofs;
									3'd1: ring2_q.y0 <= ofs;
									3'd2: ring2_q.x1 <= ofs;
									3'd3: ring2_q.y1 <= ofs;
									default: ring2_q.z1 <= ofs;
								endcase
							end else begin
								case (item_q)
									3'd0: ring1_q.x0 <= ofs;
									3'd1: ring1_q.y0 <= ofs;
									3'd2: ring1_q.x1 <= ofs;
									3'd3: ring1_q.y1 <= ofs;
									default: ring1_q.z1 <= ofs;
								endcase
							end
							if (item_q == 3'd4) begin
								cnt_q <= '0;
								if (tsel_q) begin
									state_q <= S_EMIT;
								end else begin
									tsel_q  <= 1'b1;
									state_q <= S_ABS;
								end
							end
						end
					endcase
				end
				S_EMIT: begin
					if (out_free) begin
						md_q  <= tmrg_pkg::TDATA_W'({ev[2], ev[1], ev[0]});
						mu_q  <= {ec, eq};
						ml_q  <= (cnt_q[3:0] == 4'd15);
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q[3:0] == 4'd15) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = md_q;
	assign m_tuser  = mu_q;
	assign m_tlast  = ml_q;

	// the sixteenth vertex is quad 3, corner 3
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == 4'hF))
		else $error("last vertex not at quad 3 corner 3");

	// squares only see normalized magnitudes
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ) |-> (!ovf))
		else $error("magnitude above normalization limit");

	// sines and cosines stay within one
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OFF) |-> ((t_q[1] <= ONE) && (t_q[1] >= -ONE) &&
			(t_q[2] <= ONE) && (t_q[2] >= -ONE)))
		else $error("trig value out of range");

endmodule

@@ src/tube_mesh_ring_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tube_mesh_ring_generator: tube mesh ring generator top level
// Turns a stream of curve points into quads of a square tube around the curve.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* takes one point per request (x, y, z signed Q11.12); s_tuser set
//    starts a new curve with this point.
//  - The first three points of a curve are only stored.
//    Each further point yields 16 vertices on m_*, quad-major, with m_tlast
//    on the sixteenth.
//  - cfg_* writes the tube radius (unsigned Q4.12); write only while idle.
//  - Each window-closing point is processed by the bit-serial back end: per
//    tangent two 32-step square roots and four 17-step ratios, plus offsets;
//    its 16 vertices follow. The back end takes its next job only once idle.
//  - A two-entry job queue lets up to two further windows be accepted while
//    the back end works; s_tready drops when it is full.
//  - When m_tready is low the output register holds and the back end waits.
//  - Reset clears the window, the queue and the output; radius returns to 410.
// ----------------------------------------------------------------------------
module tube_mesh_ring_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tmrg_pkg::TDATA_W-1:0]  s_tdata,   // point_x, point_y, point_z
	input  logic                          s_tuser,   // new_curve
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tmrg_pkg::TDATA_W-1:0]  m_tdata,   // vertex_x, vertex_y, vertex_z
	output logic [tmrg_pkg::TUSER_W-1:0]  m_tuser,   // quad_number, corner
	output logic                          m_tlast,   // last_of_run
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tmrg_pkg::RADIUS_W-1:0] cfg_data   // tube_radius
);

	logic [tmrg_pkg::RADIUS_W-1:0] radius_q;
	tmrg_pkg::q_stat_t             qstat;
	tmrg_pkg::job_t                push_job;
	tmrg_pkg::job_t                head_job;
	logic                          push;
	logic                          pop;

	// radius register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= tmrg_pkg::RADIUS_W'(tmrg_pkg::RADIUS_RESET);
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= cfg_data;
		end
	end

	tmrg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.qstat    (qstat),
		.push     (push),
		.job      (push_job)
	);

	tmrg_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.rdata  (head_job),
		.stat   (qstat)
	);

	tmrg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (head_job),
		.qstat    (qstat),
		.pop      (pop),
		.radius   (radius_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for tube_mesh_ring_generator
// Streams curve points into the block and predicts each window's 16 tube
// vertices with a behavioral model kept inside the bench. A directed table
// covers the corner cases, then random curves run under several radius
// settings with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb;
	import tmrg_pkg::*;

	localparam int  TRIG_UNIT  = 65536;
	localparam int  DRAIN_WAIT = 400;       // margin for the back end to return to idle
	localparam int  CYCLE_CAP  = 1000000;
	localparam int  HOLD_LEN   = 3000;
	localparam int  RUN_ITEMS  = 92;        // random points per radius phase
	localparam int  QUIET_TAIL = 60;        // no idling over the final points
	localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct {
		coord_t     vx, vy, vz;
		logic [1:0] quad, corner;
		logic       last;
	} vertex_t;

	typedef struct {
		coord_t x, y, z;
		logic   nc;
		int     nres;   // vertices this point should close
	} point_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [TUSER_W-1:0]   m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [RADIUS_W-1:0]  cfg_data = '0;

	// bench copy of the block state
	longint  win [0:8];
	int      win_count;
	longint  radius_q;
	longint  ring_off [0:1][0:3][0:2];
	vertex_t vertex_fifo [$];

	int  errors = 0;
	int  cycles = 0;
	bit  quiet = 1'b0;
	bit  hold_req = 1'b0;
	coord_t cur_x, cur_y, cur_z;

	tube_mesh_ring_generator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("%0t timeout", $time);
			$display("** tube_mesh_ring_generator: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// arithmetic of the ring orientation
	// ------------------------------------------------------------------------
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint trig_ratio(longint unsigned a, longint unsigned r);
		longint unsigned q;
		if (r == 0)
			return TRIG_UNIT;
		q = ((a << 16) + (r >> 1)) / r;
		return (q > TRIG_UNIT) ? TRIG_UNIT : longint'(q);
	endfunction

	// 32-fraction-bit product times radius, back to coordinate units
	function automatic longint radius_scale(longint t);
		longint unsigned mag;
		mag = (t < 0) ? longint'(-t) : t;
		mag = (mag * longint'(radius_q) + (64'h1 << (SCALE_SH - 1))) >> SCALE_SH;
		return (t < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	// ring offsets for tangent (dx,dy,dz) into ring_off[sel]
	task automatic build_ring(input int sel, input longint dx, dy, dz);
		longint unsigned mx, my, mz, mmax, sxy, rxy;
		longint cos_t, sin_t, cos_p, sin_p;
		mx = (dx < 0) ? -dx : dx;
		my = (dy < 0) ? -dy : dy;
		mz = (dz < 0) ? -dz : dz;
		mmax = mx;
		if (my > mmax) mmax = my;
		if (mz > mmax) mmax = mz;
		while (mmax >= (64'h1 << 30)) begin
			mmax >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
		end
		sxy = mx * mx + my * my;
		rxy = floor_sqrt(sxy);
		// vertical tangent: azimuth pinned
		if (mx == 0 && my == 0) begin
			cos_t = TRIG_UNIT;
			sin_t = 0;
		end else begin
			cos_t = trig_ratio(mx, rxy);
			sin_t = trig_ratio(my, rxy);
			if ((dy < 0) != (dx < 0))
				sin_t = -sin_t;
		end
		// zero-length tangent: polar angle pinned as well
		if (mx == 0 && my == 0 && mz == 0) begin
			cos_p = TRIG_UNIT;
			sin_p = 0;
		end else begin
			cos_p = trig_ratio(mz, floor_sqrt(sxy + mz * mz));
			if (dz < 0)
				cos_p = -cos_p;
			sin_p = trig_ratio(rxy, floor_sqrt(sxy + mz * mz));
		end
		ring_off[sel][0][0] = radius_scale(cos_p * TRIG_UNIT);
		ring_off[sel][0][1] = radius_scale(sin_p * TRIG_UNIT);
		ring_off[sel][0][2] = 0;
		ring_off[sel][1][0] = radius_scale(sin_p * sin_t);
		ring_off[sel][1][1] = radius_scale(-(cos_p * sin_t));
		ring_off[sel][1][2] = radius_scale(cos_t * TRIG_UNIT);
		for (int i = 0; i < 3; i++) begin
			ring_off[sel][2][i] = -ring_off[sel][0][i];
			ring_off[sel][3][i] = -ring_off[sel][1][i];
		end
	endtask

	function automatic coord_t clamp_coord(longint v);
		if (v > longint'(signed'(C_MAX))) return C_MAX;
		if (v < longint'(signed'(C_MIN))) return C_MIN;
		return coord_t'(v);
	endfunction

	// one accepted point: update window, queue the quads it closes
	task automatic predict_segment(input coord_t x, y, z, input logic nc, output int n);
		longint p3 [0:2];
		longint v [0:2];
		vertex_t vt;
		int k1;
		n = 0;
		p3[0] = x; p3[1] = y; p3[2] = z;
		if (nc)
			win_count = 0;
		if (win_count >= 3) begin
			build_ring(0, win[6] - win[0], win[7] - win[1], win[8] - win[2]);
			build_ring(1, p3[0] - win[3], p3[1] - win[4], p3[2] - win[5]);
			for (int q = 0; q < 4; q++) begin
				k1 = (q + 1) % 4;
				for (int c = 0; c < 4; c++) begin
					for (int i = 0; i < 3; i++) begin
						case (c)
							0: v[i] = win[3 + i] + ring_off[0][q][i];
							1: v[i] = win[6 + i] + ring_off[1][q][i];
							2: v[i] = win[6 + i] + ring_off[1][k1][i];
							default: v[i] = win[3 + i] + ring_off[0][k1][i];
						endcase
					end
					vt.vx = clamp_coord(v[0]);
					vt.vy = clamp_coord(v[1]);
					vt.vz = clamp_coord(v[2]);
					vt.quad = 2'(q);
					vt.corner = 2'(c);
					vt.last = (n == 15);
					vertex_fifo.push_back(vt);
					n++;
				end
			end
		end
		if (win_count < 3) begin
			for (int i = 0; i < 3; i++)
				win[win_count * 3 + i] = p3[i];
			win_count++;
		end else begin
			for (int i = 0; i < 6; i++)
				win[i] = win[i + 3];
			for (int i = 0; i < 3; i++)
				win[6 + i] = p3[i];
		end
	endtask

	// ------------------------------------------------------------------------
	// output side: stall bursts, one long hold-off on request
	// ------------------------------------------------------------------------
	int rx_wait = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_cnt <= HOLD_LEN;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else if (hold_cnt > 1) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (hold_cnt == 1) begin
			hold_cnt <= 0;
			m_tready <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			m_tready <= (rx_wait == 1);
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			rx_wait <= $urandom_range(1, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each vertex with the oldest prediction
	always @(posedge clk) begin
		vertex_t e;
		coord_t ax, ay, az;
		if (arst_n && m_tvalid && m_tready) begin
			ax = m_tdata[CW-1:0];
			ay = m_tdata[2*CW-1:CW];
			az = m_tdata[3*CW-1:2*CW];
			if (vertex_fifo.size() == 0) begin
				$display("%0t unexpected vertex x=%0d y=%0d z=%0d", $time, ax, ay, az);
				errors++;
			end else begin
				e = vertex_fifo.pop_front();
				if (ax !== e.vx || ay !== e.vy || az !== e.vz) begin
					$display("%0t vertex mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
						$time, e.vx, e.vy, e.vz, ax, ay, az);
					errors++;
				end
				if (m_tuser[1:0] !== e.quad || m_tuser[3:2] !== e.corner) begin
					$display("%0t quad/corner mismatch: expected %0d/%0d got %0d/%0d",
						$time, e.quad, e.corner, m_tuser[1:0], m_tuser[3:2]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t tlast mismatch: expected %0b got %0b",
						$time, e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------
	task automatic send_point(input coord_t x, y, z, input logic nc, input bit gaps,
		output int n);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		s_tuser <= nc;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_segment(x, y, z, nc, n);
		if (gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		while (vertex_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_radius(input logic [RADIUS_W-1:0] r);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		radius_q = r;
	endtask

	// next point of a random curve: mostly small steps, some wild ones
	task automatic next_point(output coord_t x, y, z, output logic nc);
		int sel;
		nc = ($urandom_range(0, 19) == 0);
		sel = $urandom_range(0, 15);
		if (nc || sel == 0) begin
			cur_x = coord_t'($urandom);
			cur_y = coord_t'($urandom);
			cur_z = coord_t'($urandom);
		end else if (sel == 1) begin
			// repeat the point: zero-length tangent later on
		end else if (sel == 2) begin
			cur_z = coord_t'(cur_z + coord_t'($urandom_range(0, 16383)) - 8192);
		end else if (sel == 3) begin
			cur_x = ($urandom_range(0, 1)) ? C_MAX : C_MIN;
			cur_y = ($urandom_range(0, 1)) ? C_MAX : C_MIN;
		end else begin
			cur_x = coord_t'(cur_x + coord_t'($urandom_range(0, 32767)) - 16384);
			cur_y = coord_t'(cur_y + coord_t'($urandom_range(0, 32767)) - 16384);
			cur_z = coord_t'(cur_z + coord_t'($urandom_range(0, 32767)) - 16384);
		end
		x = cur_x; y = cur_y; z = cur_z;
	endtask

	point_row_t dir_rows [24] = '{
		'{24'sd0,      24'sd0,     24'sd0,     1'b1, 0},
		'{24'sd4096,   24'sd0,     24'sd0,     1'b0, 0},
		'{24'sd8192,   24'sd0,     24'sd0,     1'b0, 0},
		'{24'sd12288,  24'sd0,     24'sd0,     1'b0, 16},
		'{24'sd12288,  24'sd4096,  24'sd0,     1'b0, 16},
		'{24'sd12288,  24'sd4096,  24'sd4096,  1'b0, 16},
		'{-24'sd7000,  24'sd9000,  -24'sd300,  1'b0, 16},
		// vertical tangents
		'{24'sd0,      24'sd0,     24'sd0,     1'b1, 0},
		'{24'sd0,      24'sd0,     24'sd4096,  1'b0, 0},
		'{24'sd0,      24'sd0,     24'sd8192,  1'b0, 0},
		'{24'sd0,      24'sd0,     24'sd12288, 1'b0, 16},
		// zero-length tangents
		'{24'sd1000,   24'sd2000,  24'sd3000,  1'b1, 0},
		'{24'sd1000,   24'sd2000,  24'sd3000,  1'b0, 0},
		'{24'sd1000,   24'sd2000,  24'sd3000,  1'b0, 0},
		'{24'sd1000,   24'sd2000,  24'sd3000,  1'b0, 16},
		// full-scale swings, saturated vertices
		'{C_MAX,       C_MAX,      C_MAX,      1'b1, 0},
		'{C_MIN,       C_MIN,      C_MIN,      1'b0, 0},
		'{C_MAX,       C_MAX,      C_MAX,      1'b0, 0},
		'{C_MIN,       C_MIN,      C_MIN,      1'b0, 16},
		'{C_MAX,       C_MIN,      C_MAX,      1'b0, 16},
		// restart in the middle of a curve
		'{24'sd5,      -24'sd5,    24'sd7,     1'b1, 0},
		'{24'sd4100,   24'sd3,     -24'sd9,    1'b0, 0},
		'{24'sd8200,   -24'sd40,   24'sd60,    1'b0, 0},
		'{24'sd12000,  24'sd100,   24'sd900,   1'b0, 16}
	};

	logic [RADIUS_W-1:0] phase_radius [0:4];

	initial begin
		coord_t x, y, z;
		logic nc;
		int n;
		for (int i = 0; i < 9; i++)
			win[i] = 0;
		win_count = 0;
		radius_q = RADIUS_RESET;
		cur_x = 0; cur_y = 0; cur_z = 0;
		phase_radius[0] = 16'd0;
		phase_radius[1] = 16'hFFFF;
		phase_radius[2] = 16'($urandom);
		phase_radius[3] = 16'd1;
		phase_radius[4] = 16'($urandom_range(200, 8000));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset radius
		foreach (dir_rows[i]) begin
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].nc, 1'b1, n);
			if (n != dir_rows[i].nres) begin
				$display("%0t row %0d: expected %0d vertices, model gives %0d",
					$time, i, dir_rows[i].nres, n);
				errors++;
			end
		end

		// random curves under each radius setting
		for (int ph = 0; ph < 5; ph++) begin
			s_tvalid <= 1'b0;
			wait_idle();
			write_radius(phase_radius[ph]);
			for (int k = 0; k < RUN_ITEMS; k++) begin
				if (ph == 2 && k == 10)
					hold_req <= 1'b1;
				if (ph == 4 && k == RUN_ITEMS - QUIET_TAIL)
					quiet = 1'b1;
				next_point(x, y, z, nc);
				send_point(x, y, z, nc, !quiet, n);
			end
		end
		s_tvalid <= 1'b0;

		while (vertex_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("** tube_mesh_ring_generator: PASSED **");
		else
			$display("** tube_mesh_ring_generator: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
src/tmrg_pkg.sv
src/tmrg_fifo.sv
src/tmrg_front.sv
src/tmrg_back.sv
src/tube_mesh_ring_generator.sv
tb/sv/tb.sv
